@@ hw/rtl/lolp_pkg.sv @@
// Package for the look-at orthographic line projector.
// Holds payload structs, register indexes, fixed-point widths and the setup sequencer states.
// No dependencies; included by scoped name from hw/rtl/look_at_ortho_line_projector.sv.
`default_nettype none

package lolp_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COEF_BITS     = 30;
    localparam int NUM_REGS      = 6;
    localparam int ADDR_W        = 5;
    localparam int CNT_W         = 5;

    // Datapath widths: difference, rotated coordinate, negated zoom, scaled product.
    localparam int DIFF_W = 33;
    localparam int ROT_W  = 35;
    localparam int NZ_W   = 33;
    localparam int PROD_W = 68;

    localparam logic [2:0] REG_CAMERA_X   = 3'd0;
    localparam logic [2:0] REG_CAMERA_Y   = 3'd1;
    localparam logic [2:0] REG_CAMERA_Z   = 3'd2;
    localparam logic [2:0] REG_OFFSET_X   = 3'd3;
    localparam logic [2:0] REG_OFFSET_Y   = 3'd4;
    localparam logic [2:0] REG_ZOOM       = 3'd5;

    // Coefficient indexes for the shared divider.
    localparam logic [1:0] OP_C1 = 2'd0;
    localparam logic [1:0] OP_S1 = 2'd1;
    localparam logic [1:0] OP_C2 = 2'd2;
    localparam logic [1:0] OP_S2 = 2'd3;

    typedef enum logic [2:0] {
        DRV_IDLE,
        DRV_SQUARE,
        DRV_SQRT_D,
        DRV_SQRT_L,
        DRV_LOAD,
        DRV_DIVIDE
    } drv_state_t;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] end_z;
        logic [23:0]        line_colour;
    } line_item_t;

    typedef struct packed {
        logic signed [31:0] screen_start_x;
        logic signed [31:0] screen_start_y;
        logic signed [31:0] screen_end_x;
        logic signed [31:0] screen_end_y;
        logic [23:0]        colour_out;
    } screen_item_t;

endpackage

`default_nettype wire

@@ hw/rtl/look_at_ortho_line_projector.sv @@
// Top level of the look-at orthographic line projector: APB register file,
// camera coefficient setup sequencer and the seven-stage projection pipeline.
// Depends on lolp_pkg.
`default_nettype none

// The block takes one 3D line segment per transfer on the item channel and returns its two
// projected endpoints and its colour as one transfer on the result channel. The pipeline has
// seven register stages (subtract camera, first rotation multiply, first rotation sum, second
// rotation multiply, second rotation sum, zoom multiply, shift, offset and saturate), and a new
// segment can be taken in every cycle while no setup runs and the result is not stalled; a
// stalled result holds only the full stages behind it that have no empty stage between. Writing
// camera_x, camera_y or camera_z starts the coefficient setup: three squares on one multiplier,
// two 32-step integer square roots on one shared unit and four 31-step restoring divisions on
// one shared divider, each division after a load state; item_ready stays low throughout the
// setup. Offset and zoom writes take effect at once. All coordinates are signed fixed point
// with FRAC_BITS fraction bits; results saturate to 32 bits.

module look_at_ortho_line_projector #(
    parameter int FRAC_BITS = lolp_pkg::FRAC_BITS_DEF
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire [lolp_pkg::ADDR_W-1:0]    paddr,
    input  wire [31:0]                    pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  wire                           item_valid,
    output logic                          item_ready,
    input  lolp_pkg::line_item_t          item,
    output logic                          result_valid,
    input  wire                           result_ready,
    output lolp_pkg::screen_item_t        result
);

    localparam int DW = lolp_pkg::DIFF_W;
    localparam int RW = lolp_pkg::ROT_W;
    localparam int NW = lolp_pkg::NZ_W;
    localparam int PW = lolp_pkg::PROD_W;
    localparam int CB = lolp_pkg::COEF_BITS;
    localparam int NSTAGE = 7;
    localparam logic signed [31:0] ZOOM_ONE = 32'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [31:0] COEF_ONE = 32'(64'sd1 <<< CB);

    // ------------------------------------------------------------------
    // Register file
    // ------------------------------------------------------------------
    logic signed [31:0] cam_x_reg, cam_y_reg, cam_z_reg;
    logic signed [31:0] off_x_reg, off_y_reg, zoom_reg;
    logic [2:0]         reg_idx;
    logic               wr_en;
    logic               cam_wr;

    assign reg_idx = paddr[lolp_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign cam_wr  = wr_en && (reg_idx inside {lolp_pkg::REG_CAMERA_X, lolp_pkg::REG_CAMERA_Y,
                                               lolp_pkg::REG_CAMERA_Z});
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg <= '0;
            cam_y_reg <= '0;
            cam_z_reg <= '0;
            off_x_reg <= '0;
            off_y_reg <= '0;
            zoom_reg  <= ZOOM_ONE;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                lolp_pkg::REG_CAMERA_X: cam_x_reg <= pwdata;
                lolp_pkg::REG_CAMERA_Y: cam_y_reg <= pwdata;
                lolp_pkg::REG_CAMERA_Z: cam_z_reg <= pwdata;
                lolp_pkg::REG_OFFSET_X: off_x_reg <= pwdata;
                lolp_pkg::REG_OFFSET_Y: off_y_reg <= pwdata;
                lolp_pkg::REG_ZOOM:     zoom_reg  <= pwdata;
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            lolp_pkg::REG_CAMERA_X: prdata = cam_x_reg;
            lolp_pkg::REG_CAMERA_Y: prdata = cam_y_reg;
            lolp_pkg::REG_CAMERA_Z: prdata = cam_z_reg;
            lolp_pkg::REG_OFFSET_X: prdata = off_x_reg;
            lolp_pkg::REG_OFFSET_Y: prdata = off_y_reg;
            lolp_pkg::REG_ZOOM:     prdata = zoom_reg;
            default:                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Coefficient setup: squares, shared square root, shared divider.
    // c1 = cy/d, s1 = cx/d, c2 = d/l, s2 = cz/l, all in Q2.30.
    // ------------------------------------------------------------------
    lolp_pkg::drv_state_t drv_state_reg, drv_state_next;
    logic [lolp_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]         op_reg, op_next;
    logic [63:0]        sq_reg, sq_next;
    logic [63:0]        d2_reg, d2_next;
    logic [63:0]        l2_reg, l2_next;
    logic [63:0]        rad_reg, rad_next;
    logic [33:0]        rem_reg, rem_next;
    logic [31:0]        root_reg, root_next;
    logic [31:0]        d_reg, d_next;
    logic [31:0]        l_reg, l_next;
    logic [31:0]        den_reg, den_next;
    logic               neg_reg, neg_next;
    logic [30:0]        q_reg, q_next;
    logic signed [31:0] c1_reg, c1_next, s1_reg, s1_next;
    logic signed [31:0] c2_reg, c2_next, s2_reg, s2_next;

    logic signed [31:0] sq_src;
    logic [31:0]        sq_mag;
    logic [35:0]        sr_wide;
    logic [35:0]        sr_trial;
    logic               sr_ge;
    logic [31:0]        sr_root;
    logic signed [31:0] num_src;
    logic [31:0]        num_mag;
    logic [33:0]        dv_cand;
    logic               dv_ge;
    logic [30:0]        dv_q;
    logic signed [31:0] dv_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drv_state_reg <= lolp_pkg::DRV_IDLE;
            cnt_reg       <= '0;
            op_reg        <= lolp_pkg::OP_C1;
            c1_reg        <= COEF_ONE;
            s1_reg        <= '0;
            c2_reg        <= COEF_ONE;
            s2_reg        <= '0;
        end
        else
        begin
            drv_state_reg <= drv_state_next;
            cnt_reg       <= cnt_next;
            op_reg        <= op_next;
            c1_reg        <= c1_next;
            s1_reg        <= s1_next;
            c2_reg        <= c2_next;
            s2_reg        <= s2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg   <= sq_next;
        d2_reg   <= d2_next;
        l2_reg   <= l2_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        d_reg    <= d_next;
        l_reg    <= l_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        q_reg    <= q_next;
    end

    always_comb
    begin
        drv_state_next = drv_state_reg;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        sq_next   = sq_reg;
        d2_next   = d2_reg;
        l2_next   = l2_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        d_next    = d_reg;
        l_next    = l_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        q_next    = q_reg;
        c1_next   = c1_reg;
        s1_next   = s1_reg;
        c2_next   = c2_reg;
        s2_next   = s2_reg;

        // Square of one camera coordinate per cycle.
        case (cnt_reg[1:0])
            2'd0:    sq_src = cam_x_reg;
            2'd1:    sq_src = cam_y_reg;
            default: sq_src = cam_z_reg;
        endcase
        sq_mag = sq_src[31] ? 32'(-sq_src) : sq_src;

        // One radix-4 digit of the integer square root.
        sr_wide  = {rem_reg, rad_reg[63:62]};
        sr_trial = {2'b00, root_reg, 2'b01};
        sr_ge    = (sr_wide >= sr_trial);
        sr_root  = {root_reg[30:0], sr_ge};

        // Numerator of the current divide.
        case (op_reg)
            lolp_pkg::OP_C1: num_src = cam_y_reg;
            lolp_pkg::OP_S1: num_src = cam_x_reg;
            lolp_pkg::OP_S2: num_src = cam_z_reg;
            default:         num_src = '0;
        endcase
        if (op_reg == lolp_pkg::OP_C2)
            num_mag = d_reg;
        else
            num_mag = num_src[31] ? 32'(-num_src) : num_src;

        // One quotient bit; the first step compares without the shift.
        dv_cand = (cnt_reg == '0) ? rem_reg : {rem_reg[32:0], 1'b0};
        dv_ge   = (dv_cand >= {2'b00, den_reg});
        dv_q    = {q_reg[29:0], dv_ge};
        dv_res  = neg_reg ? -$signed({1'b0, dv_q}) : $signed({1'b0, dv_q});

        case (drv_state_reg)
            lolp_pkg::DRV_IDLE:
            begin
            end
            lolp_pkg::DRV_SQUARE:
            begin
                sq_next  = 64'(sq_mag) * 64'(sq_mag);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'd1)
                    d2_next = sq_reg;
                else if (cnt_reg == 5'd2)
                    d2_next = d2_reg + sq_reg;
                else if (cnt_reg == 5'd3)
                begin
                    l2_next        = d2_reg + sq_reg;
                    rad_next       = d2_reg;
                    rem_next       = '0;
                    root_next      = '0;
                    cnt_next       = '0;
                    drv_state_next = lolp_pkg::DRV_SQRT_D;
                end
            end
            lolp_pkg::DRV_SQRT_D, lolp_pkg::DRV_SQRT_L:
            begin
                rem_next  = sr_ge ? 34'(sr_wide - sr_trial) : sr_wide[33:0];
                root_next = sr_root;
                rad_next  = {rad_reg[61:0], 2'b00};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == '1)
                begin
                    cnt_next = '0;
                    if (drv_state_reg == lolp_pkg::DRV_SQRT_D)
                    begin
                        d_next         = sr_root;
                        rad_next       = l2_reg;
                        rem_next       = '0;
                        root_next      = '0;
                        drv_state_next = lolp_pkg::DRV_SQRT_L;
                    end
                    else
                    begin
                        l_next         = sr_root;
                        op_next        = lolp_pkg::OP_C1;
                        drv_state_next = lolp_pkg::DRV_LOAD;
                    end
                end
            end
            lolp_pkg::DRV_LOAD:
            begin
                den_next = (op_reg inside {lolp_pkg::OP_C1, lolp_pkg::OP_S1}) ? d_reg : l_reg;
                rem_next = {2'b00, num_mag};
                neg_next = (op_reg != lolp_pkg::OP_C2) && num_src[31];
                q_next   = '0;
                cnt_next = '0;
                drv_state_next = lolp_pkg::DRV_DIVIDE;
            end
            lolp_pkg::DRV_DIVIDE:
            begin
                rem_next = dv_ge ? 34'(dv_cand - {2'b00, den_reg}) : dv_cand;
                q_next   = dv_q;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'd30)
                begin
                    // A zero divisor means the camera sits on an axis: identity rotation.
                    case (op_reg)
                        lolp_pkg::OP_C1: c1_next = (d2_reg == '0) ? COEF_ONE : dv_res;
                        lolp_pkg::OP_S1: s1_next = (d2_reg == '0) ? '0 : dv_res;
                        lolp_pkg::OP_C2: c2_next = (l2_reg == '0) ? COEF_ONE : dv_res;
                        default:         s2_next = (l2_reg == '0) ? '0 : dv_res;
                    endcase
                    if (op_reg == lolp_pkg::OP_S2)
                        drv_state_next = lolp_pkg::DRV_IDLE;
                    else
                    begin
                        op_next        = op_reg + 1'b1;
                        drv_state_next = lolp_pkg::DRV_LOAD;
                    end
                end
            end
            default:
            begin
                drv_state_next = lolp_pkg::DRV_IDLE;
            end
        endcase

        // A camera write restarts the setup with the new value.
        if (cam_wr)
        begin
            drv_state_next = lolp_pkg::DRV_SQUARE;
            cnt_next       = '0;
        end
    end

    // ------------------------------------------------------------------
    // Projection pipeline, two lanes (start and end point).
    // ------------------------------------------------------------------
    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] adv;

    // Stage 0: point minus camera.
    logic signed [DW-1:0] a0_reg [2], b0_reg [2], e0_reg [2];
    // Stage 1: first rotation products.
    logic signed [DW+31:0] bs1_reg [2], ac1_reg [2], as1_reg [2], bc1_reg [2];
    logic signed [DW-1:0]  e1_reg [2];
    // Stage 2: rotated X and W.
    logic signed [RW-1:0] x2_reg [2], w2_reg [2];
    logic signed [DW-1:0] e2_reg [2];
    // Stage 3: second rotation products.
    logic signed [DW+31:0] ec2_reg [2];
    logic signed [RW+31:0] ws2_reg [2];
    logic signed [RW-1:0]  x3_reg [2];
    // Stage 4: rotated Y.
    logic signed [RW-1:0] x4_reg [2], y4_reg [2];
    // Stage 5: zoom products.
    logic signed [PW-1:0] px5_reg [2], py5_reg [2];
    logic [23:0] col_reg [NSTAGE-1];
    lolp_pkg::screen_item_t res_reg;

    logic signed [31:0]   pt_x [2], pt_y [2], pt_z [2];
    logic signed [NW-1:0] nzoom;
    logic signed [RW+31:0] sum1_x [2], sum1_w [2];
    logic signed [RW+32:0] sum2_y [2];
    logic signed [PW:0]   scl_x [2], scl_y [2];
    logic signed [31:0]   sat_x [2], sat_y [2];

    assign pt_x[0] = item.start_x;
    assign pt_y[0] = item.start_y;
    assign pt_z[0] = item.start_z;
    assign pt_x[1] = item.end_x;
    assign pt_y[1] = item.end_y;
    assign pt_z[1] = item.end_z;
    assign nzoom   = -$signed({zoom_reg[31], zoom_reg});

    // A stage advances when it is empty or the stage after it advances.
    always_comb
    begin
        adv[NSTAGE-1] = !vld_reg[NSTAGE-1] || result_ready;
        for (int k = NSTAGE - 2; k >= 0; k--)
            adv[k] = !vld_reg[k] || adv[k+1];
    end

    assign item_ready   = adv[0] && (drv_state_reg == lolp_pkg::DRV_IDLE);
    assign result_valid = vld_reg[NSTAGE-1];
    assign result       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (adv[0])
                vld_reg[0] <= item_valid && item_ready;
            for (int k = 1; k < NSTAGE; k++)
                if (adv[k])
                    vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            sum1_x[i] = (RW+32)'(bs1_reg[i]) - (RW+32)'(ac1_reg[i]);
            sum1_w[i] = -(RW+32)'(as1_reg[i]) - (RW+32)'(bc1_reg[i]);
            sum2_y[i] = (RW+33)'(ec2_reg[i]) + (RW+33)'(ws2_reg[i]);
            scl_x[i]  = (PW+1)'(px5_reg[i] >>> FRAC_BITS) + (PW+1)'(off_x_reg);
            scl_y[i]  = (PW+1)'(py5_reg[i] >>> FRAC_BITS) + (PW+1)'(off_y_reg);
            if (scl_x[i] > (PW+1)'(32'sh7FFF_FFFF))
                sat_x[i] = 32'sh7FFF_FFFF;
            else if (scl_x[i] < -(PW+1)'(33'sh0_8000_0000))
                sat_x[i] = 32'sh8000_0000;
            else
                sat_x[i] = scl_x[i][31:0];
            if (scl_y[i] > (PW+1)'(32'sh7FFF_FFFF))
                sat_y[i] = 32'sh7FFF_FFFF;
            else if (scl_y[i] < -(PW+1)'(33'sh0_8000_0000))
                sat_y[i] = 32'sh8000_0000;
            else
                sat_y[i] = scl_y[i][31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 2; i++)
        begin
            if (adv[0])
            begin
                a0_reg[i] <= DW'(pt_x[i]) - DW'(cam_x_reg);
                b0_reg[i] <= DW'(pt_y[i]) - DW'(cam_y_reg);
                e0_reg[i] <= DW'(pt_z[i]) - DW'(cam_z_reg);
            end
            if (adv[1])
            begin
                bs1_reg[i] <= (DW+32)'(b0_reg[i]) * (DW+32)'(s1_reg);
                ac1_reg[i] <= (DW+32)'(a0_reg[i]) * (DW+32)'(c1_reg);
                as1_reg[i] <= (DW+32)'(a0_reg[i]) * (DW+32)'(s1_reg);
                bc1_reg[i] <= (DW+32)'(b0_reg[i]) * (DW+32)'(c1_reg);
                e1_reg[i]  <= e0_reg[i];
            end
            if (adv[2])
            begin
                x2_reg[i] <= RW'(sum1_x[i] >>> CB);
                w2_reg[i] <= RW'(sum1_w[i] >>> CB);
                e2_reg[i] <= e1_reg[i];
            end
            if (adv[3])
            begin
                ec2_reg[i] <= (DW+32)'(e2_reg[i]) * (DW+32)'(c2_reg);
                ws2_reg[i] <= (RW+32)'(w2_reg[i]) * (RW+32)'(s2_reg);
                x3_reg[i]  <= x2_reg[i];
            end
            if (adv[4])
            begin
                y4_reg[i] <= RW'(sum2_y[i] >>> CB);
                x4_reg[i] <= x3_reg[i];
            end
            if (adv[5])
            begin
                px5_reg[i] <= PW'(x4_reg[i]) * PW'(zoom_reg);
                py5_reg[i] <= PW'(y4_reg[i]) * PW'(nzoom);
            end
        end
        if (adv[0])
            col_reg[0] <= item.line_colour;
        for (int k = 1; k < NSTAGE - 1; k++)
            if (adv[k])
                col_reg[k] <= col_reg[k-1];
        if (adv[NSTAGE-1])
        begin
            res_reg.screen_start_x <= sat_x[0];
            res_reg.screen_start_y <= sat_y[0];
            res_reg.screen_end_x   <= sat_x[1];
            res_reg.screen_end_y   <= sat_y[1];
            res_reg.colour_out     <= col_reg[NSTAGE-2];
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_take_while_setup: assert property (@(posedge clk) disable iff (!rst_n)
        (drv_state_reg != lolp_pkg::DRV_IDLE) |-> !item_ready)
        else $error("item taken during coefficient setup");

    a_cam_write_starts_setup: assert property (@(posedge clk) disable iff (!rst_n)
        cam_wr |=> (drv_state_reg == lolp_pkg::DRV_SQUARE))
        else $error("camera write did not start setup");

    a_take_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> vld_reg[0])
        else $error("taken item lost at first stage");

    a_coef_range: assert property (@(posedge clk) disable iff (!rst_n)
        (drv_state_reg == lolp_pkg::DRV_IDLE) |->
            ((c1_reg <= COEF_ONE) && (c1_reg >= -COEF_ONE) &&
             (s2_reg <= COEF_ONE) && (s2_reg >= -COEF_ONE)))
        else $error("rotation coefficient out of range");

endmodule

`default_nettype wire

@@ tb/sv/look_at_ortho_line_projector_tb.sv @@
// Self-checking testbench for look_at_ortho_line_projector.
// Drives line segments and APB register writes and checks every projected result against a
// behavioral predictor kept in this file. Depends on lolp_pkg and the block's RTL.
`timescale 1ns / 100ps

module look_at_ortho_line_projector_tb;

    localparam int FRAC = 16;
    localparam int COEF = 30;
    // An index past the register list; the block must ignore writes to it.
    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef logic signed [127:0] wide_t;

    logic           clk;
    logic           rst_n;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [lolp_pkg::ADDR_W-1:0] paddr;
    logic [31:0]    pwdata;
    logic [31:0]    prdata;
    logic           pready;
    logic           item_valid;
    logic           item_ready;
    lolp_pkg::line_item_t   item;
    logic           result_valid;
    logic           result_ready;
    lolp_pkg::screen_item_t result;

    // Predictor copy of the registers and of the rotation coefficients (Q2.30).
    longint         cam_reg [lolp_pkg::NUM_REGS];
    longint         cos_yaw, sin_yaw, cos_pitch, sin_pitch;

    lolp_pkg::screen_item_t pending_screens [$];
    int             error_count = 0;
    int             sender_max_gap = 12;
    int             receiver_max_stall = 12;
    // A nonzero value makes the receiver hold off once; the value sets the length of that hold.
    int             receiver_hold = 0;

    look_at_ortho_line_projector DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Floor integer square root, bit by bit.
    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // num / den in Q2.30, truncated toward zero.
    function automatic longint coef_ratio(longint num, longint unsigned den);
        longint unsigned mag;
        longint unsigned quo;
        mag = (num < 0) ? longint'(-num) : num;
        quo = (mag << COEF) / den;
        return (num < 0) ? -longint'(quo) : longint'(quo);
    endfunction

    // Recomputes the rotation coefficients from the camera position.
    function automatic void update_rotation();
        longint cx, cy, cz;
        longint unsigned d2, l2, dist_xy, dist_xyz;
        cx = cam_reg[lolp_pkg::REG_CAMERA_X];
        cy = cam_reg[lolp_pkg::REG_CAMERA_Y];
        cz = cam_reg[lolp_pkg::REG_CAMERA_Z];
        d2 = longint'(cx * cx) + longint'(cy * cy);
        l2 = d2 + longint'(cz * cz);
        dist_xy = floor_sqrt(d2);
        dist_xyz = floor_sqrt(l2);
        if (d2 == 0)
        begin
            cos_yaw = longint'(1) << COEF;
            sin_yaw = 0;
        end
        else
        begin
            cos_yaw = coef_ratio(cy, dist_xy);
            sin_yaw = coef_ratio(cx, dist_xy);
        end
        if (l2 == 0)
        begin
            cos_pitch = longint'(1) << COEF;
            sin_pitch = 0;
        end
        else
        begin
            cos_pitch = coef_ratio(longint'(dist_xy), dist_xyz);
            sin_pitch = coef_ratio(cz, dist_xyz);
        end
    endfunction

    // floor(v * z / 2^FRAC) + off, saturated to 32-bit signed.
    function automatic logic signed [31:0] zoom_and_clamp(wide_t v, wide_t z, wide_t off);
        wide_t q;
        q = ((v * z) >>> FRAC) + off;
        if (q > wide_t'(32'sh7fffffff))
            q = wide_t'(32'sh7fffffff);
        if (q < -wide_t'(64'sh80000000))
            q = -wide_t'(64'sh80000000);
        return q[31:0];
    endfunction

    function automatic void project_point(input logic signed [31:0] px, py, pz,
                                          output logic signed [31:0] sx, sy);
        wide_t a, b, e, xr, wr, yr;
        a = wide_t'(px) - cam_reg[lolp_pkg::REG_CAMERA_X];
        b = wide_t'(py) - cam_reg[lolp_pkg::REG_CAMERA_Y];
        e = wide_t'(pz) - cam_reg[lolp_pkg::REG_CAMERA_Z];
        xr = (b * sin_yaw - a * cos_yaw) >>> COEF;
        wr = (-(a * sin_yaw) - b * cos_yaw) >>> COEF;
        yr = (e * cos_pitch + wr * sin_pitch) >>> COEF;
        sx = zoom_and_clamp(xr, cam_reg[lolp_pkg::REG_ZOOM], cam_reg[lolp_pkg::REG_OFFSET_X]);
        sy = zoom_and_clamp(yr, -wide_t'(cam_reg[lolp_pkg::REG_ZOOM]),
                            cam_reg[lolp_pkg::REG_OFFSET_Y]);
    endfunction

    function automatic lolp_pkg::screen_item_t project_line(lolp_pkg::line_item_t seg);
        lolp_pkg::screen_item_t s;
        project_point(seg.start_x, seg.start_y, seg.start_z, s.screen_start_x,
                      s.screen_start_y);
        project_point(seg.end_x, seg.end_y, seg.end_z, s.screen_end_x, s.screen_end_y);
        s.colour_out = seg.line_colour;
        return s;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got, exp_val);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, exp_val, $realtime);
        error_count++;
    endtask

    // Checks every result transfer against the oldest outstanding projection.
    always @(posedge clk)
    begin
        lolp_pkg::screen_item_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_screens.size() == 0)
            begin
                $display("MISMATCH unexpected result at %0t", $realtime);
                error_count++;
            end
            else
            begin
                want = pending_screens.pop_front();
                if (result.screen_start_x !== want.screen_start_x)
                    report_mismatch("screen_start_x", result.screen_start_x,
                                    want.screen_start_x);
                if (result.screen_start_y !== want.screen_start_y)
                    report_mismatch("screen_start_y", result.screen_start_y,
                                    want.screen_start_y);
                if (result.screen_end_x !== want.screen_end_x)
                    report_mismatch("screen_end_x", result.screen_end_x, want.screen_end_x);
                if (result.screen_end_y !== want.screen_end_y)
                    report_mismatch("screen_end_y", result.screen_end_y, want.screen_end_y);
                if (result.colour_out !== want.colour_out)
                    report_mismatch("colour_out", result.colour_out, want.colour_out);
            end
        end
    end

    // Receiver: stalls a random number of cycles before each transfer, and once holds off
    // for a long stretch when a test asks for it.
    initial
    begin
        int stall;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (receiver_hold > 0)
            begin
                stall = receiver_hold;
                receiver_hold = 0;
            end
            else if ($urandom_range(0, 3) == 0)
                stall = 0;
            else
                stall = $urandom_range(0, receiver_max_stall);
            if (stall > 0)
            begin
                @(negedge clk);
                result_ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            result_ready <= 1'b1;
            do @(posedge clk); while (!(result_valid && result_ready));
        end
    end

    // Offers one segment after a random gap and records its projection once it is taken.
    task automatic send_line(input lolp_pkg::line_item_t seg);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, sender_max_gap);
        if (gap > 0)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        item_valid <= 1'b1;
        item <= seg;
        do @(posedge clk); while (!(item_valid && item_ready));
        pending_screens.push_back(project_line(seg));
    endtask

    // Waits until every result is back and the pipeline has drained.
    task automatic drain();
        @(negedge clk);
        item_valid <= 1'b0;
        wait (pending_screens.size() == 0);
        repeat (12) @(posedge clk);
    endtask

    // APB write: setup cycle then access cycle. A camera write starts the coefficient
    // setup, so the task returns only once the block takes segments again.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= lolp_pkg::ADDR_W'(idx) << 2;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (idx < lolp_pkg::NUM_REGS)
        begin
            cam_reg[idx] = longint'(signed'(value));
            update_rotation();
        end
        repeat (2) @(posedge clk);
        wait (item_ready);
    endtask

    task automatic write_all(input logic [31:0] cx, cy, cz, ox, oy, zm);
        write_reg(lolp_pkg::REG_CAMERA_X, cx);
        write_reg(lolp_pkg::REG_CAMERA_Y, cy);
        write_reg(lolp_pkg::REG_CAMERA_Z, cz);
        write_reg(lolp_pkg::REG_OFFSET_X, ox);
        write_reg(lolp_pkg::REG_OFFSET_Y, oy);
        write_reg(lolp_pkg::REG_ZOOM, zm);
    endtask

    // Coordinates are mostly modest so the projection does not always saturate.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000);
            default: return 32'($signed($urandom_range(0, 32'h0fffffff)) - 32'sh08000000);
        endcase
    endfunction

    function automatic lolp_pkg::line_item_t rand_line();
        lolp_pkg::line_item_t seg;
        seg.start_x = rand_coord();
        seg.start_y = rand_coord();
        seg.start_z = rand_coord();
        seg.end_x = rand_coord();
        seg.end_y = rand_coord();
        seg.end_z = rand_coord();
        seg.line_colour = $urandom_range(0, 24'hffffff);
        return seg;
    endfunction

    function automatic lolp_pkg::line_item_t make_line(input logic [31:0] v0, v1, v2, v3, v4,
                                                       v5, input logic [23:0] colour);
        lolp_pkg::line_item_t seg;
        seg = {v0, v1, v2, v3, v4, v5, colour};
        return seg;
    endfunction

    // A handful of extreme segments used under several camera settings.
    task automatic send_extremes();
        send_line(make_line(0, 0, 0, 0, 0, 0, 24'h000000));
        send_line(make_line(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                            32'h80000000, 32'h80000000, 32'h80000000, 24'hffffff));
        send_line(make_line(32'h80000000, 32'h7fffffff, 32'h80000000,
                            32'h7fffffff, 32'h80000000, 32'h7fffffff, 24'h5a5a5a));
        send_line(make_line(32'h00010000, 32'h00020000, 32'hffff0000,
                            32'hfffe0000, 32'h00030000, 32'h00000001, 24'ha5a5a5));
    endtask

    // Reset values: identity rotation, unit zoom, no offset.
    task automatic test_reset_defaults();
        send_extremes();
        repeat (4) send_line(rand_line());
        drain();
    endtask

    // Camera straight above the origin and camera at the origin give the fallback rotations.
    task automatic test_special_cameras();
        write_all(0, 0, 32'h00050000, 0, 0, 32'h00010000);
        send_extremes();
        drain();
        write_reg(lolp_pkg::REG_CAMERA_Z, 0);
        send_extremes();
        drain();
    endtask

    // Register extremes, most negative zoom included, and a write past the register list.
    task automatic test_register_extremes();
        write_all(32'h80000000, 32'h7fffffff, 32'h80000000,
                  32'h7fffffff, 32'h80000000, 32'h80000000);
        send_extremes();
        drain();
        write_all(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                  32'h80000000, 32'h7fffffff, 32'h7fffffff);
        write_reg(REG_UNUSED, 32'hdeadbeef);
        send_extremes();
        drain();
        write_all(32'h00030000, 32'hfffc0000, 32'h00020000, 32'h01000000, 32'hff000000, 0);
        send_extremes();
        drain();
    endtask

    // Random camera settings, each followed by a batch of random segments.
    task automatic test_random_views();
        for (int phase = 0; phase < 10; phase++)
        begin
            write_all(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                      ($urandom_range(0, 1) == 0) ? $urandom
                          : 32'($signed($urandom_range(0, 32'h0007ffff)) - 32'sh00040000));
            // Every third phase runs without idle cycles on either side.
            sender_max_gap = (phase % 3 == 2) ? 0 : 12;
            receiver_max_stall = (phase % 3 == 2) ? 0 : 12;
            repeat (100) send_line(rand_line());
            drain();
        end
        sender_max_gap = 12;
        receiver_max_stall = 12;
    endtask

    // The receiver holds off for a long stretch while segments keep arriving back to back,
    // so the pipeline fills and item_ready must drop.
    task automatic test_backpressure();
        sender_max_gap = 0;
        receiver_hold = 300;
        repeat (60) send_line(rand_line());
        drain();
        sender_max_gap = 12;
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        item_valid = 1'b0;
        item = '0;
        foreach (cam_reg[i])
            cam_reg[i] = 0;
        cam_reg[lolp_pkg::REG_ZOOM] = longint'(1) << FRAC;
        update_rotation();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // The block resets to identity coefficients; wait until it takes segments.
        repeat (2) @(posedge clk);
        wait (item_ready);

        test_reset_defaults();
        test_special_cameras();
        test_register_extremes();
        test_backpressure();
        test_random_views();

        if (error_count == 0)
            $display("look_at_ortho_line_projector regression: pass");
        else
            $display("look_at_ortho_line_projector regression: fail");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #5ms;
        $display("look_at_ortho_line_projector regression: fail");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/lolp_pkg.sv
hw/rtl/look_at_ortho_line_projector.sv
tb/sv/look_at_ortho_line_projector_tb.sv
